FILE: design/tbsq_pkg.sv
// Shared constants and types for the trackball button and scroll qualifier.
package tbsq_pkg;

    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 72;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CNT_W       = 7;
    localparam int FADE_W      = 8;
    localparam int DELTA_W     = 16;
    localparam int NUM_PINS    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Input tdata bit positions
    localparam int IN_MOTION = 4;
    localparam int IN_DX_LO  = 5;
    localparam int IN_DY_LO  = 21;
    localparam int PIN_SCROLL = 3;

    // Output tdata bit positions
    localparam int OUT_LED     = 0;
    localparam int OUT_LEFT    = 1;
    localparam int OUT_MIDDLE  = 2;
    localparam int OUT_RIGHT   = 3;
    localparam int OUT_REPORT  = 4;
    localparam int OUT_MX_LO   = 5;
    localparam int OUT_MY_LO   = 21;
    localparam int OUT_WX_LO   = 37;
    localparam int OUT_WY_LO   = 53;
    localparam int OUT_USED_W  = 69;

    localparam logic [CNT_W-1:0]  PRESS_THRESHOLD_RST = 7'd80;
    localparam logic [CNT_W-1:0]  WINDOW_LENGTH_RST   = 7'd100;
    localparam logic [CNT_W-1:0]  LIGHT_RELOAD_RST    = 7'd50;
    localparam logic [FADE_W-1:0] FADE_DELAY_RST      = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESS_THRESHOLD = 2'd0,
        REG_WINDOW_LENGTH   = 2'd1,
        REG_LIGHT_RELOAD    = 2'd2,
        REG_FADE_DELAY      = 2'd3
    } cfg_reg_t;

    // Result of the first stage, ahead of the wheel division
    typedef struct packed {
        logic                      led_on;
        logic                      window_end;
        logic                      left_pressed;
        logic                      middle_pressed;
        logic                      right_pressed;
        logic                      move_report;
        logic signed [DELTA_W-1:0] move_x;
        logic signed [DELTA_W-1:0] move_y;
        logic                      pass_x;
        logic                      pass_y;
        logic signed [DELTA_W-1:0] acc_x;
        logic signed [DELTA_W-1:0] acc_y;
    } stage_t;

endpackage

FILE: design/trackball_button_scroll_qualifier.sv
// Trackball button qualifier, LED fade and scroll accumulation, top level.
// An accepted transaction is held in the first-stage register, then in the output register.
// Throughput: one transaction per cycle unless m_tready stalls; state updates only on accept.
// The wheel value divides by SCROLL_LIMIT with a reciprocal multiply in the output stage.
// Reset: asynchronous, active low; clears counters, light level, accumulators and valids,
// and loads the registers with their default values.
module trackball_button_scroll_qualifier #(
    parameter int unsigned SCROLL_LIMIT = 15
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tbsq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tbsq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // left_pin, middle_pin, right_pin, scroll_pin, motion_valid, delta_x[16], delta_y[16]
    input  logic [tbsq_pkg::S_DATA_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // led_on, left_pressed, middle_pressed, right_pressed, move_report,
    // move_x[16], move_y[16], wheel_x[16], wheel_y[16]
    output logic [tbsq_pkg::M_DATA_W-1:0]         m_tdata,
    // window_end
    output logic                                  m_tlast
);

    localparam int DW = tbsq_pkg::DELTA_W;
    localparam int CW = tbsq_pkg::CNT_W;
    localparam int RECIP_SHIFT = DW + 8;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCROLL_LIMIT) - 64'd1) / 64'(SCROLL_LIMIT));
    localparam logic signed [DW:0] LIMIT_POS = (DW+1)'(SCROLL_LIMIT);
    localparam logic signed [DW:0] LIMIT_NEG = -LIMIT_POS;
    localparam logic signed [DW:0] SAT_MAX = (DW+1)'(17'sd32767);
    localparam logic signed [DW:0] SAT_MIN = -(DW+1)'(17'sd32768);

    // Configuration registers
    logic [CW-1:0]                   press_threshold_reg;
    logic [CW-1:0]                   window_length_reg;
    logic [CW-1:0]                   light_reload_reg;
    logic [tbsq_pkg::FADE_W-1:0]     fade_delay_reg;

    // Block state
    logic [CW-1:0]                   tick_reg, tick_next;
    logic [CW-1:0]                   low_cnt_reg [tbsq_pkg::NUM_PINS];
    logic [CW-1:0]                   low_cnt_next [tbsq_pkg::NUM_PINS];
    logic [CW-1:0]                   cnt_upd [tbsq_pkg::NUM_PINS];
    logic [CW-1:0]                   light_reg, light_next;
    logic [tbsq_pkg::FADE_W-1:0]     fade_reg, fade_next;
    logic signed [DW-1:0]            acc_x_reg, acc_x_next;
    logic signed [DW-1:0]            acc_y_reg, acc_y_next;

    // Pipeline
    logic                            a_valid_reg, a_valid_next;
    tbsq_pkg::stage_t                a_reg, a_next;
    logic                            out_valid_reg, out_valid_next;
    logic [tbsq_pkg::M_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;

    logic                            advance;
    logic                            accept;

    // First stage signals
    logic [CW-1:0]                   win_len;
    logic                            last_tick;
    logic [tbsq_pkg::NUM_PINS-1:0]   pressed;
    logic                            motion;
    logic signed [DW-1:0]            dx;
    logic signed [DW-1:0]            dy;
    logic signed [DW:0]              sum_x;
    logic signed [DW:0]              sum_y;
    logic signed [DW-1:0]            sat_x;
    logic signed [DW-1:0]            sat_y;
    logic                            pass_x;
    logic                            pass_y;
    logic [CW-1:0]                   light_faded;

    // Second stage signals
    logic signed [DW-1:0]            wheel_x;
    logic signed [DW-1:0]            wheel_y;

    function automatic logic signed [DW-1:0] div_limit(input logic signed [DW-1:0] v);
        logic [DW:0]             mag;
        logic [DW+RECIP_W:0]     prod;
        logic [DW:0]             quo;
        logic [DW:0]             res;
        mag  = v[DW-1] ? -{v[DW-1], v} : {v[DW-1], v};
        prod = (DW+RECIP_W+1)'(mag) * (DW+RECIP_W+1)'(RECIP);
        quo  = prod[RECIP_SHIFT +: DW+1];
        res  = v[DW-1] ? -quo : quo;
        return res[DW-1:0];
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_threshold_reg <= tbsq_pkg::PRESS_THRESHOLD_RST;
            window_length_reg   <= tbsq_pkg::WINDOW_LENGTH_RST;
            light_reload_reg    <= tbsq_pkg::LIGHT_RELOAD_RST;
            fade_delay_reg      <= tbsq_pkg::FADE_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (tbsq_pkg::cfg_reg_t'(cfg_index))
                tbsq_pkg::REG_PRESS_THRESHOLD: press_threshold_reg <= cfg_data[CW-1:0];
                tbsq_pkg::REG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[CW-1:0];
                tbsq_pkg::REG_LIGHT_RELOAD:    light_reload_reg    <= cfg_data[CW-1:0];
                tbsq_pkg::REG_FADE_DELAY:      fade_delay_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        win_len   = (window_length_reg == '0) ? CW'(1) : window_length_reg;
        last_tick = ({1'b0, tick_reg} + 8'd1) >= {1'b0, win_len};
        motion    = s_tdata[tbsq_pkg::IN_MOTION];
        dx        = s_tdata[tbsq_pkg::IN_DX_LO +: DW];
        dy        = s_tdata[tbsq_pkg::IN_DY_LO +: DW];

        for (int k = 0; k < tbsq_pkg::NUM_PINS; k++)
        begin
            cnt_upd[k] = (!s_tdata[k] && low_cnt_reg[k] != tbsq_pkg::CNT_MAX)
                         ? low_cnt_reg[k] + CW'(1) : low_cnt_reg[k];
            pressed[k] = cnt_upd[k] > press_threshold_reg;
        end

        sum_x = {acc_x_reg[DW-1], acc_x_reg} + {dx[DW-1], dx};
        sum_y = {acc_y_reg[DW-1], acc_y_reg} - {dy[DW-1], dy};
        sat_x = (sum_x > SAT_MAX) ? SAT_MAX[DW-1:0] :
                (sum_x < SAT_MIN) ? SAT_MIN[DW-1:0] : sum_x[DW-1:0];
        sat_y = (sum_y > SAT_MAX) ? SAT_MAX[DW-1:0] :
                (sum_y < SAT_MIN) ? SAT_MIN[DW-1:0] : sum_y[DW-1:0];
        pass_x = ($signed({sat_x[DW-1], sat_x}) > LIMIT_POS)
                 || ($signed({sat_x[DW-1], sat_x}) < LIMIT_NEG);
        pass_y = ($signed({sat_y[DW-1], sat_y}) > LIMIT_POS)
                 || ($signed({sat_y[DW-1], sat_y}) < LIMIT_NEG);

        light_faded = light_reg;
        fade_next   = fade_reg;
        if (light_reg != '0)
        begin
            if (fade_reg == fade_delay_reg)
            begin
                light_faded = light_reg - CW'(1);
                fade_next   = '0;
            end
            else
            begin
                fade_next = fade_reg + tbsq_pkg::FADE_W'(1);
            end
        end

        // Hold state unless a transaction is taken
        tick_next  = tick_reg;
        light_next = light_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        for (int k = 0; k < tbsq_pkg::NUM_PINS; k++)
        begin
            low_cnt_next[k] = low_cnt_reg[k];
        end

        a_next                = '0;
        a_next.led_on         = tick_reg < light_reg;
        a_next.window_end     = last_tick;
        a_next.left_pressed   = last_tick && pressed[0];
        a_next.middle_pressed = last_tick && pressed[1];
        a_next.right_pressed  = last_tick && pressed[2];
        a_next.move_report    = last_tick && motion;
        a_next.acc_x          = sat_x;
        a_next.acc_y          = sat_y;

        if (!accept)
        begin
            fade_next = fade_reg;
        end
        else if (!last_tick)
        begin
            fade_next = fade_reg;
            tick_next = tick_reg + CW'(1);
            for (int k = 0; k < tbsq_pkg::NUM_PINS; k++)
            begin
                low_cnt_next[k] = cnt_upd[k];
            end
        end
        else
        begin
            tick_next  = '0;
            light_next = light_faded;
            for (int k = 0; k < tbsq_pkg::NUM_PINS; k++)
            begin
                low_cnt_next[k] = '0;
            end
            if (motion)
            begin
                light_next = light_reload_reg;
                if (pressed[tbsq_pkg::PIN_SCROLL])
                begin
                    a_next.pass_x = pass_x;
                    a_next.pass_y = pass_y;
                    acc_x_next    = pass_x ? '0 : sat_x;
                    acc_y_next    = pass_y ? '0 : sat_y;
                end
                else
                begin
                    a_next.move_x = dx;
                    a_next.move_y = dy;
                    acc_x_next    = '0;
                    acc_y_next    = '0;
                end
            end
        end

        a_valid_next = s_tready ? s_tvalid : a_valid_reg;
    end

    always_comb
    begin
        wheel_x = a_reg.pass_x ? div_limit(a_reg.acc_x) : '0;
        wheel_y = a_reg.pass_y ? div_limit(a_reg.acc_y) : '0;

        out_data_next                            = '0;
        out_data_next[tbsq_pkg::OUT_LED]         = a_reg.led_on;
        out_data_next[tbsq_pkg::OUT_LEFT]        = a_reg.left_pressed;
        out_data_next[tbsq_pkg::OUT_MIDDLE]      = a_reg.middle_pressed;
        out_data_next[tbsq_pkg::OUT_RIGHT]       = a_reg.right_pressed;
        out_data_next[tbsq_pkg::OUT_REPORT]      = a_reg.move_report;
        out_data_next[tbsq_pkg::OUT_MX_LO +: DW] = a_reg.move_x;
        out_data_next[tbsq_pkg::OUT_MY_LO +: DW] = a_reg.move_y;
        out_data_next[tbsq_pkg::OUT_WX_LO +: DW] = wheel_x;
        out_data_next[tbsq_pkg::OUT_WY_LO +: DW] = wheel_y;
        out_last_next                            = a_reg.window_end;
        out_valid_next = advance ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            light_reg     <= '0;
            fade_reg      <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < tbsq_pkg::NUM_PINS; k++)
            begin
                low_cnt_reg[k] <= '0;
            end
        end
        else
        begin
            tick_reg      <= tick_next;
            light_reg     <= light_next;
            fade_reg      <= fade_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < tbsq_pkg::NUM_PINS; k++)
            begin
                low_cnt_reg[k] <= low_cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            a_reg <= a_next;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

FILE: design/tbsq_checker.sv
// Port-level assertions for the trackball button and scroll qualifier, with its bind.
module tbsq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tbsq_pkg::M_DATA_W-1:0]       m_tdata,
    input logic                                m_tlast
);

    localparam int DW = tbsq_pkg::DELTA_W;

    // Hold a stalled transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled transaction changed");

    // Drop every field but the LED outside the window's last tick
    a_mid_window_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[tbsq_pkg::OUT_USED_W-1:tbsq_pkg::OUT_LEFT] == '0)
        else $error("mid-window transaction carries report fields");

    // Motion and wheel values only appear with a movement report
    a_move_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[tbsq_pkg::OUT_USED_W-1:tbsq_pkg::OUT_MX_LO] != '0
        |-> m_tdata[tbsq_pkg::OUT_REPORT])
        else $error("movement without report");

    // Pointer movement and wheel steps exclude each other
    a_move_or_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[tbsq_pkg::OUT_WX_LO +: DW] != '0
                     || m_tdata[tbsq_pkg::OUT_WY_LO +: DW] != '0)
        |-> m_tdata[tbsq_pkg::OUT_MX_LO +: 2*DW] == '0)
        else $error("pointer movement alongside wheel steps");

endmodule

bind trackball_button_scroll_qualifier tbsq_checker u_tbsq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
